// ===== rtl/core/ehm_pkg.sv =====
// Shared codes, job types and constants for the epoch hash map.
`default_nettype none
package ehm_pkg;
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_EPOCH  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] ST_DONE = 3'd0;
   localparam logic [2:0] ST_HIT  = 3'd1;
   localparam logic [2:0] ST_MISS = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_LONG = 3'd4;

   localparam logic CSR_PRIME_A = 1'b0;
   localparam logic CSR_PRIME_B = 1'b1;

   localparam logic [31:0] PRIME_A_RESET = 32'd151;
   localparam logic [31:0] PRIME_B_RESET = 32'd163;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {JOB_INSERT, JOB_LOOKUP, JOB_LONG, JOB_EPOCH} job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  low_a;
      logic [31:0]  low_b;
      logic [31:0]  value;
   } job_head_type;

   localparam int HEAD_W = $bits(job_head_type);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;
endpackage
`default_nettype wire

// ===== rtl/core/ehm_req_if.sv =====
// Request channel interface: key byte transactions.
`default_nettype none
interface ehm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  key_byte;
   logic        key_last;
   logic [31:0] value;
   modport source(output valid, cmd, key_byte, key_last, value, input ready);
   modport sink(input valid, cmd, key_byte, key_last, value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ehm_rsp_if.sv =====
// Response channel interface: operation results.
`default_nettype none
interface ehm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] found_value;
   logic [5:0]  slot_index;
   modport source(output valid, status, found_value, slot_index, input ready);
   modport sink(input valid, status, found_value, slot_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ehm_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none
module ehm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/core/ehm_front.sv =====
// Front end: absorbs key bytes, builds both hash accumulators, issues jobs.
`default_nettype none
module ehm_front #(
   parameter int MAX_KEY_BYTES = 32,
   localparam int CNT_W = $clog2(MAX_KEY_BYTES + 1),
   localparam int IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
   localparam int KEY_W = MAX_KEY_BYTES * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   ehm_req_if.sink              req,
   input  logic [31:0]          prime_a,
   input  logic [31:0]          prime_b,
   input  logic                 hold,
   input  logic                 q_full,
   output logic                 push,
   output ehm_pkg::job_head_type job_head,
   output logic [CNT_W-1:0]     job_len,
   output logic [KEY_W-1:0]     job_key
);
   import ehm_pkg::*;

   logic [63:0]      acc_a_ff, acc_b_ff;
   logic [63:0]      pa_lo_ff, pb_lo_ff;
   logic [31:0]      pa_hi_ff, pb_hi_ff;
   logic [7:0]       byte_ff;
   logic             busy_ff, last_ff, ovf_ff;
   job_kind_type     kind_ff;
   logic [31:0]      value_ff;
   logic [CNT_W-1:0] len_ff, seen_ff;
   logic [7:0]       key_buf_ff [MAX_KEY_BYTES];

   logic             accept, room, ovf_in;
   logic [CNT_W-1:0] seen_in;
   logic [63:0]      sum_a, sum_b;

   assign req.ready = !busy_ff && !q_full && !hold;
   assign accept    = req.valid && req.ready;
   assign room      = seen_ff < CNT_W'(MAX_KEY_BYTES);
   assign seen_in   = room ? seen_ff + CNT_W'(1) : seen_ff;
   assign ovf_in    = ovf_ff || !room;

   assign sum_a = acc_a_ff + pa_lo_ff + {pa_hi_ff, 32'd0} + {56'd0, byte_ff};
   assign sum_b = acc_b_ff + pb_lo_ff + {pb_hi_ff, 32'd0} + {56'd0, byte_ff};

   assign push = (accept && req.cmd == CMD_EPOCH) || (busy_ff && last_ff);

   always_comb begin
      job_head.kind  = busy_ff ? kind_ff : JOB_EPOCH;
      job_head.low_a = sum_a[31:0];
      job_head.low_b = sum_b[31:0];
      job_head.value = value_ff;
      job_len        = len_ff;
      for (int j = 0; j < MAX_KEY_BYTES; j++) begin
         job_key[j*8 +: 8] = key_buf_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         last_ff  <= 1'b0;
         seen_ff  <= '0;
         ovf_ff   <= 1'b0;
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else begin
         if (busy_ff) begin
            busy_ff  <= 1'b0;
            acc_a_ff <= last_ff ? 64'd0 : sum_a;
            acc_b_ff <= last_ff ? 64'd0 : sum_b;
         end
         if (accept && (req.cmd inside {CMD_INSERT, CMD_LOOKUP})) begin
            busy_ff  <= 1'b1;
            last_ff  <= req.key_last;
            byte_ff  <= req.key_byte;
            value_ff <= req.value;
            pa_lo_ff <= 64'(acc_a_ff[31:0]) * 64'(prime_a);
            pb_lo_ff <= 64'(acc_b_ff[31:0]) * 64'(prime_b);
            pa_hi_ff <= acc_a_ff[63:32] * prime_a;
            pb_hi_ff <= acc_b_ff[63:32] * prime_b;
            if (room) begin
               key_buf_ff[seen_ff[IDX_W-1:0]] <= req.key_byte;
            end
            if (req.key_last) begin
               len_ff  <= seen_in;
               kind_ff <= ovf_in ? JOB_LONG :
                          (req.cmd == CMD_INSERT ? JOB_INSERT : JOB_LOOKUP);
               seen_ff <= '0;
               ovf_ff  <= 1'b0;
            end else begin
               seen_ff <= seen_in;
               ovf_ff  <= ovf_in;
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/ehm_queue.sv =====
// Job queue between front and back ends.
`default_nettype none
module ehm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output ehm_pkg::queue_status_type status
);
   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;

   assign pop_data     = entry_ff[rd_ff];
   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            entry_ff[wr_ff] <= push_data;
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/ehm_back.sv =====
// Back end: hash reduction, double-hash probing over the slot RAM, results.
`default_nettype none
module ehm_back #(
   parameter int TABLE_SIZE = 64,
   parameter int MAX_KEY_BYTES = 32,
   localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1),
   localparam int KEY_W = MAX_KEY_BYTES * 8,
   localparam int IDX_W = $clog2(TABLE_SIZE),
   localparam int PCNT_W = $clog2(TABLE_SIZE + 1),
   localparam int ROW_W = 64 + LEN_W + KEY_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           prime_a,
   input  logic [31:0]           prime_b,
   input  logic                  job_valid,
   input  ehm_pkg::job_head_type job_head,
   input  logic [LEN_W-1:0]      job_len,
   input  logic [KEY_W-1:0]      job_key,
   output logic                  pop,
   output logic                  clearing,
   ehm_rsp_if.source             rsp
);
   import ehm_pkg::*;

   localparam logic [32:0] RECIP = 33'((66'd1 << 33) / 66'(TABLE_SIZE));

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIV, S_MOD, S_PROBE_RD, S_PROBE_CHK, S_RESP
   } state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  clr_addr_ff, pos_ff, stride_ff;
   logic [31:0]       epoch_ff;
   job_head_type      job_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [32:0]       dv_a_ff, dv_b_ff;
   logic [31:0]       rem_a_ff, rem_b_ff;
   logic [32:0]       quo_a_ff, quo_b_ff;
   logic [5:0]        step_ff;
   logic [PCNT_W-1:0] pcnt_ff;
   logic [2:0]        res_status_ff;
   logic [31:0]       res_found_ff;
   logic [5:0]        res_slot_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [31:0]       rsp_found_ff;
   logic [5:0]        rsp_slot_ff;

   logic [31:0]       div_a, div_b, rem_a_in, rem_b_in, ha, hb;
   logic [32:0]       r2a, r2b, hb1;
   logic [65:0]       prod_a, prod_b;
   logic [32:0]       quo_a_in, quo_b_in;
   logic [33:0]       part_a, part_b;
   logic [IDX_W-1:0]  mod_a, mod_b;
   logic              ram_we, current, key_ok, len_ok, is_insert, last_probe;
   logic              rsp_load;
   logic [IDX_W-1:0]  ram_waddr, pos_in;
   logic [ROW_W-1:0]  ram_wdata, ram_rdata;
   logic [31:0]       rd_stamp, rd_value;
   logic [LEN_W-1:0]  rd_len;
   logic [KEY_W-1:0]  rd_key;
   logic [IDX_W:0]    pos_sum;
   logic [PCNT_W-1:0] pcnt_in;

   assign div_a    = prime_a;
   assign div_b    = prime_b;
   assign r2a      = {rem_a_ff, dv_a_ff[32]};
   assign r2b      = {rem_b_ff, dv_b_ff[32]};
   assign rem_a_in = (r2a >= {1'b0, div_a}) ? 32'(r2a - {1'b0, div_a}) : r2a[31:0];
   assign rem_b_in = (r2b >= {1'b0, div_b}) ? 32'(r2b - {1'b0, div_b}) : r2b[31:0];
   assign ha       = (prime_a == '0) ? job_ff.low_a : rem_a_in;
   assign hb       = (prime_b == '0) ? job_ff.low_b : rem_b_in;
   assign hb1      = {1'b0, hb} + 33'd1;

   assign prod_a   = {33'd0, dv_a_ff} * {33'd0, RECIP};
   assign prod_b   = {33'd0, dv_b_ff} * {33'd0, RECIP};
   assign quo_a_in = prod_a[65:33];
   assign quo_b_in = prod_b[65:33];
   assign part_a   = {1'b0, dv_a_ff} - (34'(quo_a_ff) * 34'(TABLE_SIZE));
   assign part_b   = {1'b0, dv_b_ff} - (34'(quo_b_ff) * 34'(TABLE_SIZE));
   assign mod_a    = (part_a >= 34'(TABLE_SIZE)) ?
                     IDX_W'(part_a - 34'(TABLE_SIZE)) : part_a[IDX_W-1:0];
   assign mod_b    = (part_b >= 34'(TABLE_SIZE)) ?
                     IDX_W'(part_b - 34'(TABLE_SIZE)) : part_b[IDX_W-1:0];

   assign rd_stamp = ram_rdata[ROW_W-1 -: 32];
   assign rd_value = ram_rdata[ROW_W-33 -: 32];
   assign rd_len   = ram_rdata[KEY_W +: LEN_W];
   assign rd_key   = ram_rdata[KEY_W-1:0];
   assign current  = rd_stamp == epoch_ff;
   assign len_ok   = rd_len == len_ff;
   assign is_insert = job_ff.kind == JOB_INSERT;

   always_comb begin
      key_ok = 1'b1;
      for (int j = 0; j < MAX_KEY_BYTES; j++) begin
         if ((32'(j) < 32'(len_ff)) && (rd_key[j*8 +: 8] != key_ff[j*8 +: 8])) begin
            key_ok = 1'b0;
         end
      end
   end

   assign pos_sum    = {1'b0, pos_ff} + {1'b0, stride_ff};
   assign pos_in     = (pos_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
                       IDX_W'(pos_sum - (IDX_W+1)'(TABLE_SIZE)) : pos_sum[IDX_W-1:0];
   assign pcnt_in    = pcnt_ff + PCNT_W'(1);
   assign last_probe = pcnt_in == PCNT_W'(TABLE_SIZE);

   assign ram_we    = (state_ff == S_CLEAR) ||
                      (state_ff == S_PROBE_CHK && is_insert && !current);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : pos_ff;
   assign ram_wdata = (state_ff == S_CLEAR) ? '0 :
                      {epoch_ff, job_ff.value, len_ff, key_ff};

   ehm_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_SIZE)) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (pos_ff),
      .rdata (ram_rdata)
   );

   assign pop      = (state_ff == S_IDLE) && job_valid;
   assign clearing = state_ff == S_CLEAR;
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.found_value = rsp_found_ff;
   assign rsp.slot_index  = rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         epoch_ff     <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp.ready);
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + IDX_W'(1);
               if (clr_addr_ff == IDX_W'(TABLE_SIZE - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_head;
                  len_ff   <= job_len;
                  key_ff   <= job_key;
                  dv_a_ff  <= {1'b0, job_head.low_a};
                  dv_b_ff  <= {1'b0, job_head.low_b};
                  rem_a_ff <= '0;
                  rem_b_ff <= '0;
                  step_ff  <= '0;
                  case (job_head.kind)
                     JOB_EPOCH: begin
                        epoch_ff <= epoch_ff + 32'd1;
                     end
                     JOB_LONG: begin
                        res_status_ff <= ST_LONG;
                        res_found_ff  <= '0;
                        res_slot_ff   <= '0;
                        state_ff      <= S_RESP;
                     end
                     default: begin
                        state_ff <= S_DIV;
                     end
                  endcase
               end
            end
            S_DIV: begin
               if (step_ff == 6'd32) begin
                  dv_a_ff  <= {1'b0, ha};
                  dv_b_ff  <= hb1;
                  step_ff  <= '0;
                  state_ff <= S_MOD;
               end else begin
                  dv_a_ff  <= {dv_a_ff[31:0], 1'b0};
                  dv_b_ff  <= {dv_b_ff[31:0], 1'b0};
                  rem_a_ff <= rem_a_in;
                  rem_b_ff <= rem_b_in;
                  step_ff  <= step_ff + 6'd1;
               end
            end
            S_MOD: begin
               if (step_ff == '0) begin
                  quo_a_ff <= quo_a_in;
                  quo_b_ff <= quo_b_in;
                  step_ff  <= 6'd1;
               end else begin
                  pos_ff    <= mod_a;
                  stride_ff <= mod_b;
                  pcnt_ff   <= '0;
                  state_ff  <= S_PROBE_RD;
               end
            end
            S_PROBE_RD: begin
               state_ff <= S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
               if (is_insert && !current) begin
                  res_status_ff <= ST_DONE;
                  res_found_ff  <= '0;
                  res_slot_ff   <= 6'(pos_ff);
                  state_ff      <= S_RESP;
               end else if (!is_insert && current && len_ok && key_ok) begin
                  res_status_ff <= ST_HIT;
                  res_found_ff  <= rd_value;
                  res_slot_ff   <= 6'(pos_ff);
                  state_ff      <= S_RESP;
               end else if (last_probe) begin
                  res_status_ff <= is_insert ? ST_FULL : ST_MISS;
                  res_found_ff  <= '0;
                  res_slot_ff   <= '0;
                  state_ff      <= S_RESP;
               end else begin
                  pos_ff   <= pos_in;
                  pcnt_ff  <= pcnt_in;
                  state_ff <= S_PROBE_RD;
               end
            end
            S_RESP: begin
               if (rsp_load) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_found_ff  <= res_found_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/epoch_hash_map_double_hashing_top.sv =====
// Epoch hash map top level: config registers, front end, job queue, back end.
// Non-final key byte: the front end is busy after each byte; epoch-advance items leave it free.
// Final key byte: queue, dispatch, serial hash reduction by the primes, reduction by
// TABLE_SIZE, a read and a check state per probe, then the output register.
// Throughput is set by the serial remainder unit and the slot RAM probe loop.
// Reset: synchronous; a clearing pass over all TABLE_SIZE slots holds req_ch.ready low.
`default_nettype none
module epoch_hash_map_double_hashing_top #(
   parameter int TABLE_SIZE = 64,
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   ehm_req_if.sink     req_ch,
   ehm_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import ehm_pkg::*;

   localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int KEY_W = MAX_KEY_BYTES * 8;
   localparam int JOB_W = HEAD_W + LEN_W + KEY_W;

   logic [31:0]      prime_a_ff, prime_b_ff;
   logic             fr_push, bk_pop, clearing;
   job_head_type     fr_head, q_head;
   logic [LEN_W-1:0] fr_len, q_len;
   logic [KEY_W-1:0] fr_key, q_key;
   logic [JOB_W-1:0] q_data;
   queue_status_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_a_ff <= PRIME_A_RESET;
         prime_b_ff <= PRIME_B_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRIME_A: prime_a_ff <= csr_wdata;
            CSR_PRIME_B: prime_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ehm_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .prime_a  (prime_a_ff),
      .prime_b  (prime_b_ff),
      .hold     (clearing),
      .q_full   (q_stat.full),
      .push     (fr_push),
      .job_head (fr_head),
      .job_len  (fr_len),
      .job_key  (fr_key)
   );

   ehm_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_push),
      .push_data ({fr_head, fr_len, fr_key}),
      .pop       (bk_pop),
      .pop_data  (q_data),
      .status    (q_stat)
   );

   assign q_head = job_head_type'(q_data[JOB_W-1 -: HEAD_W]);
   assign q_len  = q_data[KEY_W +: LEN_W];
   assign q_key  = q_data[KEY_W-1:0];

   ehm_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .prime_a   (prime_a_ff),
      .prime_b   (prime_b_ff),
      .job_valid (!q_stat.empty),
      .job_head  (q_head),
      .job_len   (q_len),
      .job_key   (q_key),
      .pop       (bk_pop),
      .clearing  (clearing),
      .rsp       (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(fr_push && q_stat.full && !bk_pop))
      else $error("job queue overflow");

   a_found_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != ST_HIT |-> rsp_ch.found_value == '0)
      else $error("found value set without hit");

   a_slot_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_MISS || rsp_ch.status == ST_FULL ||
      rsp_ch.status == ST_LONG) |-> rsp_ch.slot_index == '0)
      else $error("slot index set on failed operation");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !(req_ch.valid && req_ch.ready) && !bk_pop)
      else $error("transaction taken during clearing pass");
`endif
endmodule
`default_nettype wire

// ===== dv/ehm_table_checker.sv =====
// Watches the request, response and CSR ports, predicts the hash table answers and compares.
`default_nettype none
module ehm_table_checker #(
   parameter int TABLE_SIZE = 64,
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   ehm_req_if          req_ch,
   ehm_rsp_if          rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   output int          error_count,
   output int          answers_pending,
   output int          answers_checked,
   output int          hit_count,
   output int          full_count,
   output int          long_count
);
   import ehm_pkg::*;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] found_value;
      logic [5:0]  slot_index;
   } answer_type;

   answer_type  expected_answers[$];
   logic [31:0] prime_a, prime_b, epoch_now;
   logic [31:0] slot_stamp[TABLE_SIZE];
   logic [7:0]  slot_key[TABLE_SIZE][MAX_KEY_BYTES];
   int          slot_len[TABLE_SIZE];
   logic [31:0] slot_value[TABLE_SIZE];
   logic [7:0]  key_buf[MAX_KEY_BYTES];
   int          key_seen;
   logic        key_overflow;
   logic [63:0] acc_a, acc_b;

   assign answers_pending = expected_answers.size();

   task automatic apply_key_transaction(input logic [1:0] cmd, input logic [7:0] kb,
                                        input logic last, input logic [31:0] val);
      answer_type  ans;
      logic [31:0] ha, hb;
      logic [63:0] pos;
      int          s;
      bit          same;
      if (cmd == CMD_EPOCH) begin
         epoch_now = epoch_now + 32'd1;
         return;
      end
      if (cmd != CMD_INSERT && cmd != CMD_LOOKUP) return;
      if (key_seen < MAX_KEY_BYTES) begin
         key_buf[key_seen] = kb;
         key_seen++;
      end else begin
         key_overflow = 1'b1;
      end
      acc_a = acc_a * ({32'd0, prime_a} + 64'd1) + {56'd0, kb};
      acc_b = acc_b * ({32'd0, prime_b} + 64'd1) + {56'd0, kb};
      if (!last) return;
      ha = (prime_a == 32'd0) ? acc_a[31:0] : acc_a[31:0] % prime_a;
      hb = (prime_b == 32'd0) ? acc_b[31:0] : acc_b[31:0] % prime_b;
      ans.found_value = '0;
      ans.slot_index = '0;
      if (key_overflow) begin
         ans.status = ST_LONG;
      end else if (cmd == CMD_INSERT) begin
         ans.status = ST_FULL;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            pos = {32'd0, ha} + 64'(i) * ({32'd0, hb} + 64'd1);
            s = int'(pos % 64'(TABLE_SIZE));
            if (slot_stamp[s] != epoch_now) begin
               for (int k = 0; k < key_seen; k++) slot_key[s][k] = key_buf[k];
               slot_len[s] = key_seen;
               slot_value[s] = val;
               slot_stamp[s] = epoch_now;
               ans.status = ST_DONE;
               ans.slot_index = 6'(s);
               break;
            end
         end
      end else begin
         ans.status = ST_MISS;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            pos = {32'd0, ha} + 64'(i) * ({32'd0, hb} + 64'd1);
            s = int'(pos % 64'(TABLE_SIZE));
            if (slot_stamp[s] == epoch_now && slot_len[s] == key_seen) begin
               same = 1'b1;
               for (int k = 0; k < key_seen; k++)
                  if (slot_key[s][k] != key_buf[k]) same = 1'b0;
               if (same) begin
                  ans.status = ST_HIT;
                  ans.found_value = slot_value[s];
                  ans.slot_index = 6'(s);
                  break;
               end
            end
         end
      end
      key_seen = 0;
      key_overflow = 1'b0;
      acc_a = '0;
      acc_b = '0;
      expected_answers.push_back(ans);
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         prime_a = PRIME_A_RESET;
         prime_b = PRIME_B_RESET;
         epoch_now = 32'd1;
         for (int s = 0; s < TABLE_SIZE; s++) slot_stamp[s] = '0;
         key_seen = 0;
         key_overflow = 1'b0;
         acc_a = '0;
         acc_b = '0;
         expected_answers.delete();
         error_count = 0;
         answers_checked = 0;
         hit_count = 0;
         full_count = 0;
         long_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PRIME_A) prime_a = csr_wdata;
            else prime_b = csr_wdata;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("MISMATCH: unexpected response status=%0d value=%h slot=%0d",
                           rsp_ch.status, rsp_ch.found_value, rsp_ch.slot_index);
            end else begin
               want = expected_answers.pop_front();
               answers_checked++;
               if (want.status == ST_HIT) hit_count++;
               if (want.status == ST_FULL) full_count++;
               if (want.status == ST_LONG) long_count++;
               if (rsp_ch.status !== want.status || rsp_ch.found_value !== want.found_value
                   || rsp_ch.slot_index !== want.slot_index) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("MISMATCH: expected status=%0d value=%h slot=%0d, got %0d %h %0d",
                              want.status, want.found_value, want.slot_index,
                              rsp_ch.status, rsp_ch.found_value, rsp_ch.slot_index);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            apply_key_transaction(req_ch.cmd, req_ch.key_byte, req_ch.key_last, req_ch.value);
      end
   end
endmodule
`default_nettype wire

// ===== dv/epoch_hash_map_double_hashing_top_test.sv =====
// Stimulus, clocking and verdict for the epoch hash map testbench.
`default_nettype none
module epoch_hash_map_double_hashing_top_test;
   import ehm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;
   int          error_count, answers_pending, answers_checked;
   int          hit_count, full_count, long_count;
   int          items_sent;
   int          cycle_count;
   int          hold_cycles;
   int          rsp_max_gap;
   int          req_max_gap;
   logic [7:0]  pool_key[16][40];
   int          pool_len[16];

   ehm_req_if req_ch();
   ehm_rsp_if rsp_ch();

   epoch_hash_map_double_hashing_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ehm_table_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .answers_pending(answers_pending),
      .answers_checked(answers_checked), .hit_count(hit_count),
      .full_count(full_count), .long_count(long_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         if (rsp_max_gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(0, rsp_max_gap)) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         #1;
         while (!rsp_ch.valid || reset) begin
            @(negedge clock);
            #1;
         end
         @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(input logic [1:0] cmd, input logic [7:0] kb, input logic last,
                            input logic [31:0] val);
      int gap;
      gap = (req_max_gap > 0) ? $urandom_range(0, req_max_gap) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.cmd = cmd;
      req_ch.key_byte = kb;
      req_ch.key_last = last;
      req_ch.value = val;
      req_ch.valid = 1'b1;
      #1;
      while (!req_ch.ready) begin
         @(negedge clock);
         #1;
      end
      @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_key(input logic [1:0] cmd, input int idx, input logic [31:0] val);
      for (int k = 0; k < pool_len[idx]; k++)
         send_item(cmd, pool_key[idx][k], k == pool_len[idx] - 1, val);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (answers_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic fill_pool();
      for (int p = 0; p < 16; p++) begin
         pool_len[p] = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 6);
         for (int k = 0; k < 40; k++) pool_key[p][k] = 8'($urandom);
      end
   endtask

   task automatic run_random(input int count);
      int goal, pick, idx;
      logic [1:0] c;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         idx = $urandom_range(0, 15);
         if (pick < 45) begin
            send_key(CMD_INSERT, idx, $urandom);
         end else if (pick < 80) begin
            send_key(CMD_LOOKUP, idx, $urandom);
         end else if (pick < 85) begin
            send_item(CMD_EPOCH, 8'($urandom), 1'($urandom), $urandom);
         end else if (pick < 89) begin
            send_item(CMD_UNUSED, 8'($urandom), 1'($urandom), $urandom);
         end else if (pick < 93) begin
            pool_len[idx] = $urandom_range(33, 36);
            send_key(CMD_INSERT, idx, $urandom);
            pool_len[idx] = $urandom_range(1, 6);
         end else begin
            for (int k = 0; k < pool_len[idx]; k++) begin
               c = 2'($urandom_range(0, 1));
               if ($urandom_range(0, 5) == 0)
                  send_item(CMD_EPOCH, 8'($urandom), 1'b0, $urandom);
               send_item(c, pool_key[idx][k], k == pool_len[idx] - 1, $urandom);
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_PRIME_A;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_INSERT;
      req_ch.key_byte = '0;
      req_ch.key_last = 1'b0;
      req_ch.value = '0;
      items_sent = 0;
      hold_cycles = 0;
      rsp_max_gap = 13;
      req_max_gap = 13;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(CMD_INSERT, 8'hff, 1'b1, 32'hffff_ffff);
      send_item(CMD_LOOKUP, 8'hff, 1'b1, 32'h0);
      send_item(CMD_LOOKUP, 8'h00, 1'b1, 32'h0);
      send_item(CMD_INSERT, 8'h00, 1'b0, 32'h0);
      send_item(CMD_EPOCH, 8'h5a, 1'b1, 32'h1234);
      send_item(CMD_LOOKUP, 8'h00, 1'b1, 32'ha5a5_a5a5);
      send_item(CMD_UNUSED, 8'hff, 1'b1, 32'hffff_ffff);
      send_item(CMD_INSERT, 8'h00, 1'b0, 32'h0);
      send_item(CMD_INSERT, 8'h00, 1'b1, 32'h0000_0000);
      send_item(CMD_LOOKUP, 8'h00, 1'b0, 32'h0);
      send_item(CMD_LOOKUP, 8'h00, 1'b1, 32'h0);
      send_item(CMD_EPOCH, 8'h00, 1'b0, 32'h0);
      send_item(CMD_LOOKUP, 8'hff, 1'b1, 32'h0);
      fill_pool();
      pool_len[0] = 32;
      send_key(CMD_INSERT, 0, 32'h8000_0001);
      pool_len[1] = 33;
      send_key(CMD_LOOKUP, 1, 32'h0);
      pool_len[1] = 3;

      wait_idle();
      fill_pool();
      run_random(250);

      wait_idle();
      write_csr(CSR_PRIME_A, 32'd2);
      write_csr(CSR_PRIME_B, 32'd2);
      fill_pool();
      hold_cycles = 2500;
      run_random(250);

      wait_idle();
      write_csr(CSR_PRIME_A, 32'hffff_ffff);
      write_csr(CSR_PRIME_B, 32'hffff_ffff);
      fill_pool();
      rsp_max_gap = 0;
      req_max_gap = 0;
      run_random(250);

      wait_idle();
      write_csr(CSR_PRIME_A, 32'd0);
      write_csr(CSR_PRIME_B, $urandom_range(2, 1000));
      fill_pool();
      rsp_max_gap = 13;
      req_max_gap = 13;
      run_random(200);

      wait_idle();
      write_csr(CSR_PRIME_A, $urandom);
      write_csr(CSR_PRIME_B, $urandom);
      fill_pool();
      run_random(300);

      wait_idle();
      $display("Sent %0d key transactions over 5 prime settings; %0d answers checked",
               items_sent, answers_checked);
      $display("Lookup hits %0d, table full %0d, key too long %0d",
               hit_count, full_count, long_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Mismatches: %0d", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
